/* rtl/core/bmf_pkg.sv */
// Shared types, constants and helpers for the 3x3 box mean filter.
`timescale 1ns / 1ps

package bmf_pkg;

  // Image limits
  localparam int MAX_LINE  = 256;
  localparam int MAX_LINES = 256;

  // Field widths
  localparam int PIX_W       = 8;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int LINE_ADDR_W = $clog2(MAX_LINE);
  localparam int WD_W        = $clog2(MAX_LINE + 1);
  localparam int HT_W        = $clog2(MAX_LINES + 2);

  // Window sums: three pixels per column, nine per window
  localparam int COL_SUM_W = PIX_W + 2;
  localparam int SUM_W     = PIX_W + 4;

  // Divide by nine as multiply by ceil(2^16 / 9), exact for sums below 2^15
  localparam int DIV9_MUL   = 7282;
  localparam int DIV9_MUL_W = 13;
  localparam int DIV9_SHIFT = 16;
  localparam int PROD_W     = SUM_W + DIV9_MUL_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Reset value of both dimension registers
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // One window column, index 0 is the oldest line
  typedef logic [2:0][PIX_W-1:0] col_t;

  // Control from the sequencer to each window cell
  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

  // Clamp a written line width to 3..MAX_LINE
  function automatic logic [WD_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
    logic [WD_W-1:0] res;
    if (int'(v) < 3) begin
      res = WD_W'(3);
    end else if (int'(v) > MAX_LINE) begin
      res = WD_W'(MAX_LINE);
    end else begin
      res = WD_W'(v);
    end
    return res;
  endfunction

  // Clamp a written frame height to 3..MAX_LINES
  function automatic logic [HT_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    logic [HT_W-1:0] res;
    if (int'(v) < 3) begin
      res = HT_W'(3);
    end else if (int'(v) > MAX_LINES) begin
      res = HT_W'(MAX_LINES);
    end else begin
      res = HT_W'(v);
    end
    return res;
  endfunction

endpackage

/* rtl/core/bmf_pix_if.sv */
// Input pixel stream channel.
`timescale 1ns / 1ps

interface bmf_pix_if;
  logic                      valid;
  logic                      ready;
  logic [bmf_pkg::PIX_W-1:0] pixel_in;
  logic                      flush;

  modport source (output valid, output pixel_in, output flush, input ready);
  modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

/* rtl/core/bmf_res_if.sv */
// Output result stream channel.
`timescale 1ns / 1ps

interface bmf_res_if;
  logic                      valid;
  logic                      ready;
  logic [bmf_pkg::PIX_W-1:0] pixel_out;
  logic                      frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

/* rtl/core/bmf_cfg_if.sv */
// Register write channel.
`timescale 1ns / 1ps

interface bmf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bmf_pkg::CFG_IDX_W-1:0] index;
  logic [bmf_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/bmf_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, hold data while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/bmf_cell.sv */
// One window column cell: holds three pixels and their column sum.
`timescale 1ns / 1ps

module bmf_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  bmf_pkg::cell_ctrl_t               ctrl,
  input  bmf_pkg::col_t                     col_in,
  output bmf_pkg::col_t                     col,
  output logic [bmf_pkg::COL_SUM_W-1:0]     col_sum
);

  logic [bmf_pkg::COL_SUM_W-1:0] sum_in;

  // Sum the incoming column
  always_comb begin
    sum_in = bmf_pkg::COL_SUM_W'(col_in[0]) + bmf_pkg::COL_SUM_W'(col_in[1])
           + bmf_pkg::COL_SUM_W'(col_in[2]);
  end

  // Clear on restart, take the neighbor's column on shift
  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      col     <= '0;
      col_sum <= '0;
    end else if (ctrl.shift) begin
      col     <= col_in;
      col_sum <= sum_in;
    end
  end

endmodule

/* rtl/core/box_mean_filter_3x3.sv */
// Top level of the streaming 3x3 box mean filter.
//
// Pixels enter on pix_in in raster order, one per transaction. Each result on
// pix_out is the pixel one line plus one pixel earlier: the floor of its 3x3
// sum divided by nine for interior pixels, the pixel itself on border rows and
// columns. After the last real pixel, send line_width + 1 transactions with
// flush set to drain the frame; frame_last marks its final result. A flush
// while pixels are expected, or a pixel while draining, is taken and dropped.
// Writes on cfg (index 0 line_width, 1 frame_height, clamped to 3..256)
// restart the frame; write only while the block is idle. cfg is always ready.
// Throughput: one pixel per cycle while pix_out is not stalled. After the
// transaction that completes its window, a result passes in order through the
// line store read, window cells, window sum and divide by reciprocal registers.
// The two line stores share one 16-bit wide, 256-deep RAM read and written at
// the column address; no clearing pass is needed after reset.
// Reset: synchronous, clears the pipeline, the counters and the window, and
// sets both dimensions to 256. A stalled pix_out holds its result while the
// pipeline keeps taking pixels until its three stages are full.
`timescale 1ns / 1ps

module box_mean_filter_3x3 (
  input  logic             clk,
  input  logic             rst,
  bmf_pix_if.sink          pix_in,
  bmf_res_if.source        pix_out,
  bmf_cfg_if.sink          cfg
);

  // Dimensions and position counters
  logic [bmf_pkg::WD_W-1:0] w_eff;
  logic [bmf_pkg::HT_W-1:0] h_eff;
  logic [bmf_pkg::WD_W-1:0] col;
  logic [bmf_pkg::WD_W-1:0] col_next;
  logic [bmf_pkg::WD_W-1:0] col_inc;
  logic [bmf_pkg::HT_W-1:0] row;
  logic [bmf_pkg::HT_W-1:0] row_next;

  logic cfg_fire;
  logic wr_width;
  logic wr_height;
  logic restart;

  // Input decode
  logic                            in_fire;
  logic                            draining;
  logic                            taken;
  logic                            col_ge1;
  logic                            has_res;
  logic                            interior;
  logic                            last;
  logic [bmf_pkg::HT_W-1:0]        cr;
  logic [bmf_pkg::WD_W-1:0]        cc;
  logic [bmf_pkg::PIX_W-1:0]       px_new;
  logic [bmf_pkg::LINE_ADDR_W-1:0] addr_new;

  // Stage 1: line store read
  logic                            s1_valid;
  logic                            s1_adv;
  logic                            s1_fire;
  logic [bmf_pkg::PIX_W-1:0]       s1_px;
  logic [bmf_pkg::LINE_ADDR_W-1:0] s1_addr;
  logic                            s1_has;
  logic                            s1_int;
  logic                            s1_last;
  logic                            s1_fwd;
  logic [bmf_pkg::PIX_W-1:0]       s1_fwd_a;
  logic [bmf_pkg::PIX_W-1:0]       s1_fwd_b;
  logic [2*bmf_pkg::PIX_W-1:0]     rd_data;
  logic [bmf_pkg::PIX_W-1:0]       above;
  logic [bmf_pkg::PIX_W-1:0]       above2;

  // Stage 2: window cells
  logic                            s2_valid;
  logic                            s2_adv;
  logic                            s2_has;
  logic                            s2_int;
  logic                            s2_last;
  bmf_pkg::cell_ctrl_t             cell_ctrl;
  bmf_pkg::col_t                   new_col;
  bmf_pkg::col_t                   cols [3];
  logic [bmf_pkg::COL_SUM_W-1:0]   csum [3];
  logic [bmf_pkg::SUM_W-1:0]       win_total;

  // Stage 3: window sum
  logic                            s3_valid;
  logic                            s3_ready;
  logic [bmf_pkg::SUM_W-1:0]       s3_sum;
  logic [bmf_pkg::PIX_W-1:0]       s3_center;
  logic                            s3_int;
  logic                            s3_last;
  logic [bmf_pkg::PROD_W-1:0]      prod;
  logic [bmf_pkg::PIX_W-1:0]       quot;

  // Output register
  logic                            o_valid;
  logic                            out_free;
  logic [bmf_pkg::PIX_W-1:0]       o_pixel;
  logic                            o_last;

  // Configuration writes
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign wr_width  = cfg_fire && (cfg.index == bmf_pkg::REG_LINE_WIDTH);
  assign wr_height = cfg_fire && (cfg.index == bmf_pkg::REG_FRAME_HEIGHT);
  assign restart   = wr_width || wr_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= bmf_pkg::clamp_width(bmf_pkg::CFG_RESET);
      h_eff <= bmf_pkg::clamp_height(bmf_pkg::CFG_RESET);
    end else begin
      if (wr_width) begin
        w_eff <= bmf_pkg::clamp_width(cfg.data);
      end
      if (wr_height) begin
        h_eff <= bmf_pkg::clamp_height(cfg.data);
      end
    end
  end

  // Decode the position of the incoming transaction
  always_comb begin
    in_fire  = pix_in.valid && pix_in.ready;
    draining = row >= h_eff;
    taken    = in_fire && (pix_in.flush == draining);
    px_new   = draining ? '0 : pix_in.pixel_in;
    addr_new = col[bmf_pkg::LINE_ADDR_W-1:0];
    col_ge1  = col != '0;
    has_res  = col_ge1 ? (row != '0) : (row > bmf_pkg::HT_W'(1));
    cr       = col_ge1 ? row - bmf_pkg::HT_W'(1) : row - bmf_pkg::HT_W'(2);
    cc       = col_ge1 ? col - bmf_pkg::WD_W'(1) : w_eff - bmf_pkg::WD_W'(1);
    interior = (cr != '0)
            && ({1'b0, cr} + (bmf_pkg::HT_W + 1)'(2) <= {1'b0, h_eff})
            && (cc != '0)
            && ({1'b0, cc} + (bmf_pkg::WD_W + 1)'(2) <= {1'b0, w_eff});
    last     = (cr == h_eff - bmf_pkg::HT_W'(1)) && (cc == w_eff - bmf_pkg::WD_W'(1));
    col_inc  = col + bmf_pkg::WD_W'(1);
    if (row > h_eff) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = row + bmf_pkg::HT_W'(1);
    end else begin
      col_next = col_inc;
      row_next = row;
    end
  end

  // Advance the position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (taken) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Handshake chain, each stage moves when the next one has room; stage 2 also moves when it holds no result
  assign out_free     = !o_valid || pix_out.ready;
  assign s3_ready     = !s3_valid || out_free;
  assign s2_adv       = !s2_valid || !s2_has || s3_ready;
  assign s1_adv       = !s1_valid || s2_adv;
  assign s1_fire      = s1_valid && s2_adv;
  assign pix_in.ready = s1_adv;

  // Line stores: low byte one line above, high byte two lines above
  bmf_ram #(
    .WIDTH (2 * bmf_pkg::PIX_W),
    .DEPTH (bmf_pkg::MAX_LINE)
  ) u_lines (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr),
    .wr_data ({above, s1_px}),
    .rd_en   (s1_adv),
    .rd_addr (addr_new),
    .rd_data (rd_data)
  );

  // Bypass the store when the read raced a write to the same column
  assign above  = s1_fwd ? s1_fwd_a : rd_data[bmf_pkg::PIX_W-1:0];
  assign above2 = s1_fwd ? s1_fwd_b : rd_data[2*bmf_pkg::PIX_W-1:bmf_pkg::PIX_W];

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= taken;
      s1_fwd   <= taken && s1_fire && (addr_new == s1_addr);
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_px    <= px_new;
      s1_addr  <= addr_new;
      s1_has   <= has_res;
      s1_int   <= interior;
      s1_last  <= last;
      s1_fwd_a <= s1_px;
      s1_fwd_b <= above;
    end
  end

  // Window cells, the newest column enters at cell 2
  assign new_col[0]      = above2;
  assign new_col[1]      = above;
  assign new_col[2]      = s1_px;
  assign cell_ctrl.clr   = restart;
  assign cell_ctrl.shift = s1_fire;

  bmf_cell u_cell2 (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (cell_ctrl),
    .col_in  (new_col),
    .col     (cols[2]),
    .col_sum (csum[2])
  );

  bmf_cell u_cell1 (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (cell_ctrl),
    .col_in  (cols[2]),
    .col     (cols[1]),
    .col_sum (csum[1])
  );

  bmf_cell u_cell0 (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (cell_ctrl),
    .col_in  (cols[1]),
    .col     (cols[0]),
    .col_sum (csum[0])
  );

  // Stage 2 tags travel with the window
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_has  <= s1_has;
      s2_int  <= s1_int;
      s2_last <= s1_last;
    end
  end

  // Sum the three column sums
  assign win_total = bmf_pkg::SUM_W'(csum[0]) + bmf_pkg::SUM_W'(csum[1])
                   + bmf_pkg::SUM_W'(csum[2]);

  // Stage 3: keep only transactions that give a result
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid && s2_has;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_sum    <= win_total;
      s3_center <= cols[1][1];
      s3_int    <= s2_int;
      s3_last   <= s2_last;
    end
  end

  // Divide the window sum by nine
  assign prod = bmf_pkg::PROD_W'(s3_sum) * bmf_pkg::PROD_W'(bmf_pkg::DIV9_MUL);
  assign quot = prod[bmf_pkg::DIV9_SHIFT +: bmf_pkg::PIX_W];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      o_pixel <= s3_int ? quot : s3_center;
      o_last  <= s3_last;
    end
  end

  assign pix_out.valid      = o_valid;
  assign pix_out.pixel_out  = o_pixel;
  assign pix_out.frame_last = o_last;

  // A result waiting on a stalled output is never lost
  assert property (@(posedge clk) disable iff (rst)
    s3_valid && !out_free |=> s3_valid)
    else $error("stage 3 result dropped under stall");

  // A bypass is only armed for a live transaction
  assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> s1_valid)
    else $error("line store bypass without a transaction");

  // Column stays inside the line
  assert property (@(posedge clk) disable iff (rst)
    col < w_eff)
    else $error("column counter past line width");

  // Row never runs past the drain line
  assert property (@(posedge clk) disable iff (rst)
    {1'b0, row} <= {1'b0, h_eff} + (bmf_pkg::HT_W + 1)'(1))
    else $error("row counter past drain line");

  // The last pixel of a frame is a corner and passes through
  assert property (@(posedge clk) disable iff (rst)
    s3_valid && s3_last |-> !s3_int)
    else $error("frame end marked on an interior pixel");

endmodule

/* sim/bmf_filter_check.sv */
// Checker for the 3x3 box mean filter: tracks the channels, predicts and compares results.
`timescale 1ns / 1ps

module bmf_filter_check (
  input  logic clk,
  input  logic rst,
  bmf_pix_if   pin,
  bmf_res_if   pout,
  bmf_cfg_if   cfg,
  output int   errors,
  output int   results_due,
  output int   results_seen,
  output int   frame_ends
);
  import bmf_pkg::*;

  localparam int WINDOW_CELLS = 9;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } filtered_t;

  // Shadow of the block: registers, line stores, window and raster position
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [PIX_W-1:0] line_up1 [MAX_LINE];
  logic [PIX_W-1:0] line_up2 [MAX_LINE];
  logic [PIX_W-1:0] win [WINDOW_CELLS];
  int               col;
  int               row;
  filtered_t        filtered_q [$];

  function automatic int dim_in_use(input logic [CFG_W-1:0] v, input int hi);
    int d;
    d = int'(v);
    if (d < 3) d = 3;
    else if (d > hi) d = hi;
    return d;
  endfunction

  task automatic restart_frame();
    int k;
    col = 0;
    row = 0;
    for (k = 0; k < WINDOW_CELLS; k++) win[k] = '0;
  endtask

  // Advance the window by one transaction and queue the delayed centre result
  task automatic filter_pixel(input logic [PIX_W-1:0] px_in, input logic fl);
    int               w;
    int               h;
    int               r;
    int               c;
    int               cr;
    int               cc;
    int               sum;
    int               k;
    logic             draining;
    logic             hit;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] up1;
    logic [PIX_W-1:0] up2;
    filtered_t        res;
    w = dim_in_use(width_reg, MAX_LINE);
    h = dim_in_use(height_reg, MAX_LINES);
    r = row;
    c = col;
    draining = (r >= h);
    // drop a flush while pixels are due, and a pixel while draining
    if (fl != draining) return;
    px = draining ? '0 : px_in;

    up1 = line_up1[c];
    up2 = line_up2[c];
    line_up2[c] = up1;
    line_up1[c] = px;

    for (k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = px;

    // locate the centre pixel, one line plus one pixel back
    cr = 0;
    cc = 0;
    if (c >= 1) begin
      hit = (r >= 1);
      cr  = r - 1;
      cc  = c - 1;
    end else begin
      hit = (r >= 2);
      cr  = r - 2;
      cc  = w - 1;
    end
    if (hit) begin
      res.pixel = win[4];
      if (cr >= 1 && cr + 2 <= h && cc >= 1 && cc + 2 <= w) begin
        sum = 0;
        for (k = 0; k < WINDOW_CELLS; k++) sum += int'(win[k]);
        res.pixel = PIX_W'(sum / WINDOW_CELLS);
      end
      res.last = (cr == h - 1) && (cc == w - 1);
      filtered_q.push_back(res);
    end

    // step the raster position, wrap after the last drain transaction
    if (r >= h + 1) begin
      row = 0;
      col = 0;
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col = c;
      row = r;
    end
  endtask

  always @(posedge clk) begin
    filtered_t want;
    int        k;
    if (rst) begin
      width_reg  = CFG_RESET;
      height_reg = CFG_RESET;
      for (k = 0; k < MAX_LINE; k++) begin
        line_up1[k] = '0;
        line_up2[k] = '0;
      end
      restart_frame();
      filtered_q.delete();
      errors       = 0;
      results_seen = 0;
      frame_ends   = 0;
    end else begin
      // apply register writes; unmapped indexes change nothing
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_LINE_WIDTH: begin
            width_reg = cfg.data;
            restart_frame();
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg.data;
            restart_frame();
          end
          default: ;
        endcase
      end

      if (pin.valid && pin.ready) filter_pixel(pin.pixel_in, pin.flush);

      // compare each result transaction with the oldest prediction
      if (pout.valid && pout.ready) begin
        results_seen++;
        if (filtered_q.size() == 0) begin
          errors++;
          $display("%0t: result pixel_out %0d frame_last %0b arrived with none expected",
                   $time, pout.pixel_out, pout.frame_last);
        end else begin
          want = filtered_q.pop_front();
          if (pout.pixel_out !== want.pixel) begin
            errors++;
            $display("%0t: pixel_out expected %0d, got %0d",
                     $time, want.pixel, pout.pixel_out);
          end
          if (pout.frame_last !== want.last) begin
            errors++;
            $display("%0t: frame_last expected %0b, got %0b",
                     $time, want.last, pout.frame_last);
          end
          if (want.last) frame_ends++;
        end
      end
    end
    results_due <= filtered_q.size();
  end

endmodule

/* sim/tb.sv */
// Testbench top for the 3x3 box mean filter: stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
  import bmf_pkg::*;

  localparam int RANDOM_PIXELS = 1000;
  localparam int SETTLE        = 16;
  localparam int QUIET_LIMIT   = 500;

  // Indexes outside the register map
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 2'd3;

  typedef enum int {PX_RANDOM, PX_EXTREME, PX_BRIGHT, PX_DARK} px_style_t;

  logic clk = 1'b0;
  logic rst;
  int   quiet;
  int   real_px;
  int   frames_sent;
  bit   tx_burst;
  bit   rx_burst;
  int   chk_errors;
  int   chk_due;
  int   chk_seen;
  int   chk_frames;

  bmf_pix_if pin_ch ();
  bmf_res_if res_ch ();
  bmf_cfg_if cfg_ch ();

  box_mean_filter_3x3 uut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pin_ch),
    .pix_out (res_ch),
    .cfg     (cfg_ch)
  );

  bmf_filter_check chk (
    .clk          (clk),
    .rst          (rst),
    .pin          (pin_ch),
    .pout         (res_ch),
    .cfg          (cfg_ch),
    .errors       (chk_errors),
    .results_due  (chk_due),
    .results_seen (chk_seen),
    .frame_ends   (chk_frames)
  );

  always #1 clk = ~clk;

  // End the run when no channel moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (pin_ch.valid && pin_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Stall the result channel at random before each transaction, except in receive bursts
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(res_ch.valid && !rst)) @(posedge clk);
    end
  end

  function automatic int dim_in_use(input int v, input int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Offer one pixel transaction after a random gap; keep valid high when no gap follows
  task automatic send_item(input logic [PIX_W-1:0] px, input logic fl);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      pin_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin_ch.valid    <= 1'b1;
    pin_ch.pixel_in <= px;
    pin_ch.flush    <= fl;
    @(posedge clk);
    while (!pin_ch.ready) @(posedge clk);
  endtask

  // Hold the sender until every predicted result is out and the pipeline is empty
  task automatic drain_wait();
    pin_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send one frame plus its drain; optionally cut it short, pause, or mix in dropped items
  task automatic run_frame(input int w, input int h, input px_style_t style, input bit noisy,
                           input int cut_at, input int pause_at);
    int               n;
    logic [PIX_W-1:0] p;
    for (n = 0; n < w * h; n++) begin
      if (n == cut_at) return;
      if (n == pause_at) drain_wait();
      if (noisy && $urandom_range(0, 9) == 0) send_item(PIX_W'($urandom_range(0, 255)), 1'b1);
      case (style)
        PX_EXTREME: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        PX_BRIGHT:  p = 8'hFF - PIX_W'($urandom_range(0, 2));
        PX_DARK:    p = PIX_W'($urandom_range(0, 2));
        default:    p = PIX_W'($urandom_range(0, 255));
      endcase
      send_item(p, 1'b0);
      real_px++;
    end
    for (n = 0; n <= w; n++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_item(PIX_W'($urandom_range(0, 255)), 1'b0);
      send_item(PIX_W'($urandom_range(0, 255)), 1'b1);
    end
    frames_sent++;
  endtask

  initial begin
    logic [PIX_W-1:0] demo_px [9] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF,
                                      8'hFF, 8'h00, 8'hFF, 8'h01};
    int               k;
    int               raw_w;
    int               raw_h;
    int               fw;
    int               fh;
    int               cut;
    int               pause;
    bit               need_cfg;

    pin_ch.valid    = 1'b0;
    pin_ch.pixel_in = '0;
    pin_ch.flush    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_LINE_WIDTH;
    cfg_ch.data     = '0;
    tx_burst        = 1'b0;
    rx_burst        = 1'b0;
    real_px         = 0;
    frames_sent     = 0;
    rst             = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Smallest frame: dropped flush mid-frame, pause mid-frame, dropped pixel in the drain
    write_reg(REG_LINE_WIDTH, CFG_W'(3));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
    for (k = 0; k < 9; k++) begin
      if (k == 4) send_item(8'hA5, 1'b1);
      if (k == 6) drain_wait();
      send_item(demo_px[k], 1'b0);
    end
    for (k = 0; k < 4; k++) begin
      if (k == 2) send_item(8'h5A, 1'b0);
      send_item(8'hFF, 1'b1);
    end

    // Height below range, then restart a frame that is only partly sent
    drain_wait();
    write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
    for (k = 0; k < 5; k++) send_item(PIX_W'($urandom_range(0, 255)), 1'b0);
    drain_wait();
    write_reg(IDX_UNMAPPED_HI, '1);
    write_reg(IDX_UNMAPPED_LO, CFG_W'($urandom_range(0, 511)));

    // Largest dimensions: all-zero width with all-ones height, then full width
    write_reg(REG_LINE_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '1);
    run_frame(3, MAX_LINES, PX_RANDOM, 1'b0, -1, -1);
    drain_wait();
    write_reg(REG_LINE_WIDTH, CFG_W'(MAX_LINE));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
    run_frame(MAX_LINE, 3, PX_EXTREME, 1'b0, -1, -1);
    real_px = 0;

    // Random small frames, some back to back, some cut short and restarted
    need_cfg = 1'b1;
    fw       = 3;
    fh       = 3;
    while (real_px < RANDOM_PIXELS) begin
      if (need_cfg || $urandom_range(0, 2) == 0) begin
        drain_wait();
        if ($urandom_range(0, 5) == 0)
          write_reg($urandom_range(0, 1) ? IDX_UNMAPPED_HI : IDX_UNMAPPED_LO,
                    CFG_W'($urandom_range(0, 511)));
        raw_w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        raw_h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        if ($urandom_range(0, 1)) begin
          write_reg(REG_LINE_WIDTH, CFG_W'(raw_w));
          write_reg(REG_FRAME_HEIGHT, CFG_W'(raw_h));
        end else begin
          write_reg(REG_FRAME_HEIGHT, CFG_W'(raw_h));
          write_reg(REG_LINE_WIDTH, CFG_W'(raw_w));
        end
        fw       = dim_in_use(raw_w, MAX_LINE);
        fh       = dim_in_use(raw_h, MAX_LINES);
        need_cfg = 1'b0;
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      cut   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, fw * fh - 1) : -1;
      pause = ($urandom_range(0, 7) == 0) ? $urandom_range(1, fw * fh - 1) : -1;
      if (cut >= 0) need_cfg = 1'b1;
      run_frame(fw, fh, px_style_t'($urandom_range(0, 3)), $urandom_range(0, 3) == 0,
                cut, pause);
    end

    // Wait out every prediction, then report
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    drain_wait();
    $display("summary: %0d random-frame pixels, %0d full random frames, %0d results compared",
             real_px, frames_sent, chk_seen);
    $display("summary: %0d frame ends seen on the output", chk_frames);
    if (chk_errors == 0 && chk_due == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bmf_pkg.sv
rtl/core/bmf_pix_if.sv
rtl/core/bmf_res_if.sv
rtl/core/bmf_cfg_if.sv
rtl/core/bmf_ram.sv
rtl/core/bmf_cell.sv
rtl/core/box_mean_filter_3x3.sv
sim/bmf_filter_check.sv
sim/tb.sv
